/* hdl/qadd_pkg.sv */
// Shared types and constants for the quantized uint8 add unit.
// No dependencies; imported by qadd_rescale and quantized_uint8_add_unit.
`default_nettype none

package qadd_pkg;

    // Fixed field widths
    localparam int OPND_W     = 8;   // quantized operand / result
    localparam int OFFS_W     = 9;   // signed negated zero point
    localparam int SUMW_W     = 10;  // operand plus offset
    localparam int MULT_W     = 31;  // Q31 multiplier magnitude
    localparam int SHIFT_W    = 5;   // one shift amount
    localparam int SHIFTS_W   = 20;  // packed shift register
    localparam int CLAMP_W    = 16;  // packed clamp register
    localparam int ACC_W      = 32;  // fixed-point accumulator
    localparam int PROD_W     = ACC_W + MULT_W;
    localparam int WIDE_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Left shift applied to each operand before rescaling
    localparam int INPUT_PRESHIFT = 20;

    // Number of register stages in the datapath
    localparam int STAGES = 9;

    // Rounding term of the doubling high multiply
    localparam logic signed [WIDE_W-1:0] NUDGE = WIDE_W'(64'sd1 <<< (ACC_W - 2));

    // Register reset values
    localparam logic [MULT_W-1:0]  MULT_RESET  = MULT_W'(32'd1073741824);
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 16'hFF00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_OFFSET      = 3'd0,
        REG_SECOND_OFFSET     = 3'd1,
        REG_RESULT_OFFSET     = 3'd2,
        REG_FIRST_MULTIPLIER  = 3'd3,
        REG_SECOND_MULTIPLIER = 3'd4,
        REG_SUM_MULTIPLIER    = 3'd5,
        REG_SHIFT_AMOUNTS     = 3'd6,
        REG_CLAMP_RANGE       = 3'd7
    } cfg_reg_t;

    // Load enables for the three stages of one rescale unit
    typedef struct packed {
        logic mul;   // product register
        logic srd;   // high-half register
        logic rnd;   // rounded-shift register
    } rs_load_t;

endpackage

`default_nettype wire

/* hdl/quantized_uint8_add_unit.sv */
// Top level of the quantized uint8 add unit: register file, stage control
// and the offset, sum and clamp stages. Depends on qadd_pkg, qadd_rescale.
//
// Usage:
//   Input channel: in_valid/in_stall carry operand_a and operand_b; a
//   transaction completes on a rising edge with in_valid high and in_stall
//   low. Output channel: out_valid/out_stall carry sum_out the same way.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register on
//   a rising edge; write only while no transaction is in flight.
//   Path: an accepted transaction passes through every stage register in
//   order and appears on out_valid once it reaches the last stage.
//   Throughput: one transaction per cycle while out_stall is low, set by
//   the 9-stage pipeline (offset add, two 3-stage rescale units, sum/shift,
//   one 3-stage rescale unit, offset and clamp).
//   Stall: each stage advances when it is empty or its successor advances,
//   so bubbles collapse; in_stall rises only when all 9 stages hold valid
//   transactions and out_stall is high. Nothing is dropped or repeated.
//   Reset (rst_n low): all stages empty, registers take their reset values
//   (offsets 0, multipliers 2^30, shifts 0, clamp range 0..255).
`default_nettype none

module quantized_uint8_add_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire  [qadd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [qadd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [qadd_pkg::OPND_W-1:0]        operand_a,
    input  wire  [qadd_pkg::OPND_W-1:0]        operand_b,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [qadd_pkg::OPND_W-1:0]        sum_out
);
    import qadd_pkg::*;

    // Configuration registers
    logic [OFFS_W-1:0]   first_offset_reg;
    logic [OFFS_W-1:0]   second_offset_reg;
    logic [OPND_W-1:0]   result_offset_reg;
    logic [MULT_W-1:0]   first_multiplier_reg;
    logic [MULT_W-1:0]   second_multiplier_reg;
    logic [MULT_W-1:0]   sum_multiplier_reg;
    logic [SHIFTS_W-1:0] shift_amounts_reg;
    logic [CLAMP_W-1:0]  clamp_range_reg;

    // Stage control
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES:0]     ready;

    // Datapath
    logic signed [SUMW_W-1:0] a_next;
    logic signed [SUMW_W-1:0] b_next;
    logic signed [SUMW_W-1:0] a_reg;
    logic signed [SUMW_W-1:0] b_reg;
    logic signed [ACC_W-1:0]  a_pre;
    logic signed [ACC_W-1:0]  b_pre;
    logic signed [ACC_W-1:0]  a_scaled;
    logic signed [ACC_W-1:0]  b_scaled;
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_scaled;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  act_min;
    logic signed [ACC_W-1:0]  act_max;
    logic signed [ACC_W-1:0]  clamped;
    logic [OPND_W-1:0]        sum_out_next;
    logic [OPND_W-1:0]        sum_out_reg;

    rs_load_t load_ab;
    rs_load_t load_sum;

    // Unpacked shift fields
    logic [SHIFT_W-1:0] first_rshift;
    logic [SHIFT_W-1:0] second_rshift;
    logic [SHIFT_W-1:0] sum_lshift;
    logic [SHIFT_W-1:0] sum_rshift;

    assign first_rshift  = shift_amounts_reg[SHIFT_W-1:0];
    assign second_rshift = shift_amounts_reg[2*SHIFT_W-1:SHIFT_W];
    assign sum_lshift    = shift_amounts_reg[3*SHIFT_W-1:2*SHIFT_W];
    assign sum_rshift    = shift_amounts_reg[4*SHIFT_W-1:3*SHIFT_W];

    // ------------------------------------------------------------------
    // Register file: plain writes, no read-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_offset_reg      <= '0;
            second_offset_reg     <= '0;
            result_offset_reg     <= '0;
            first_multiplier_reg  <= MULT_RESET;
            second_multiplier_reg <= MULT_RESET;
            sum_multiplier_reg    <= MULT_RESET;
            shift_amounts_reg     <= '0;
            clamp_range_reg       <= CLAMP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIRST_OFFSET:      first_offset_reg      <= cfg_data[OFFS_W-1:0];
                REG_SECOND_OFFSET:     second_offset_reg     <= cfg_data[OFFS_W-1:0];
                REG_RESULT_OFFSET:     result_offset_reg     <= cfg_data[OPND_W-1:0];
                REG_FIRST_MULTIPLIER:  first_multiplier_reg  <= cfg_data[MULT_W-1:0];
                REG_SECOND_MULTIPLIER: second_multiplier_reg <= cfg_data[MULT_W-1:0];
                REG_SUM_MULTIPLIER:    sum_multiplier_reg    <= cfg_data[MULT_W-1:0];
                REG_SHIFT_AMOUNTS:     shift_amounts_reg     <= cfg_data[SHIFTS_W-1:0];
                REG_CLAMP_RANGE:       clamp_range_reg       <= cfg_data[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control: a stage loads when it is empty or its successor
    // loads; hold everything behind a stalled full stage
    // ------------------------------------------------------------------
    always_comb
    begin
        ready[STAGES] = !out_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall = !ready[0];

    // ------------------------------------------------------------------
    // Stage 0: add the negated zero points
    // ------------------------------------------------------------------
    always_comb
    begin
        a_next = {first_offset_reg[OFFS_W-1], first_offset_reg}
               + {{(SUMW_W-OPND_W){1'b0}}, operand_a};
        b_next = {second_offset_reg[OFFS_W-1], second_offset_reg}
               + {{(SUMW_W-OPND_W){1'b0}}, operand_b};
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-3: pre-shift and rescale each operand
    // ------------------------------------------------------------------
    assign a_pre = ACC_W'(a_reg) <<< INPUT_PRESHIFT;
    assign b_pre = ACC_W'(b_reg) <<< INPUT_PRESHIFT;

    assign load_ab.mul = ready[1];
    assign load_ab.srd = ready[2];
    assign load_ab.rnd = ready[3];

    qadd_rescale u_rescale_a (
        .clk   (clk),
        .load  (load_ab),
        .x     (a_pre),
        .mult  (first_multiplier_reg),
        .shift (first_rshift),
        .y     (a_scaled)
    );

    qadd_rescale u_rescale_b (
        .clk   (clk),
        .load  (load_ab),
        .x     (b_pre),
        .mult  (second_multiplier_reg),
        .shift (second_rshift),
        .y     (b_scaled)
    );

    // ------------------------------------------------------------------
    // Stage 4: sum the rescaled operands, then left shift; both wrap
    // ------------------------------------------------------------------
    assign sum_next = (a_scaled + b_scaled) <<< sum_lshift;

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5-7: rescale the sum
    // ------------------------------------------------------------------
    assign load_sum.mul = ready[5];
    assign load_sum.srd = ready[6];
    assign load_sum.rnd = ready[7];

    qadd_rescale u_rescale_sum (
        .clk   (clk),
        .load  (load_sum),
        .x     (sum_reg),
        .mult  (sum_multiplier_reg),
        .shift (sum_rshift),
        .y     (sum_scaled)
    );

    // ------------------------------------------------------------------
    // Stage 8: add the output zero point, clamp min first then max so a
    // crossed range yields the maximum
    // ------------------------------------------------------------------
    always_comb
    begin
        biased  = sum_scaled + $signed({{(ACC_W-OPND_W){1'b0}}, result_offset_reg});
        act_min = $signed({{(ACC_W-OPND_W){1'b0}}, clamp_range_reg[OPND_W-1:0]});
        act_max = $signed({{(ACC_W-OPND_W){1'b0}}, clamp_range_reg[CLAMP_W-1:OPND_W]});
        clamped = biased;
        if (clamped < act_min)
        begin
            clamped = act_min;
        end
        if (clamped > act_max)
        begin
            clamped = act_max;
        end
        sum_out_next = clamped[OPND_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[8])
        begin
            sum_out_reg <= sum_out_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign sum_out   = sum_out_reg;

`ifndef ASSERT_OFF
    // Input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with an empty stage or free output");

    // A transaction in the last rescale stage reaches the output next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-2] && !out_stall) |=> out_valid)
        else $error("transaction lost between rescale and clamp stages");

    // Result within an ordered activation range
    a_clamp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (clamp_range_reg[OPND_W-1:0] <= clamp_range_reg[CLAMP_W-1:OPND_W]))
        |-> ((sum_out >= clamp_range_reg[OPND_W-1:0])
             && (sum_out <= clamp_range_reg[CLAMP_W-1:OPND_W])))
        else $error("result outside activation range");

    // Crossed range gives the maximum
    a_clamp_crossed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (clamp_range_reg[OPND_W-1:0] > clamp_range_reg[CLAMP_W-1:OPND_W]))
        |-> (sum_out == clamp_range_reg[CLAMP_W-1:OPND_W]))
        else $error("crossed clamp range did not yield the maximum");
`endif

endmodule

`default_nettype wire

/* hdl/qadd_rescale.sv */
// Three-stage fixed-point rescale: Q31 doubling high multiply, then a
// rounding right shift. Depends on qadd_pkg.
`default_nettype none

module qadd_rescale (
    input  wire                                     clk,
    input  wire  qadd_pkg::rs_load_t                load,
    input  wire  signed [qadd_pkg::ACC_W-1:0]       x,
    input  wire         [qadd_pkg::MULT_W-1:0]      mult,
    input  wire         [qadd_pkg::SHIFT_W-1:0]     shift,
    output logic signed [qadd_pkg::ACC_W-1:0]       y
);
    import qadd_pkg::*;

    logic signed [WIDE_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] nudged;
    logic signed [ACC_W-1:0]  srd_next;
    logic signed [ACC_W-1:0]  srd_reg;
    logic        [ACC_W-1:0]  mask;
    logic        [ACC_W-1:0]  rem;
    logic        [ACC_W-1:0]  thr;
    logic signed [ACC_W-1:0]  y_next;
    logic signed [ACC_W-1:0]  y_reg;

    // Stage 1: signed x times non-negative multiplier
    always_comb
    begin
        prod_full = WIDE_W'(x) * WIDE_W'($signed({1'b0, mult}));
        prod_next = prod_full[PROD_W-1:0];
    end

    // Stage 2: adding 2^30 then flooring by 2^31 gives division rounded to
    // nearest, ties toward positive infinity, for both signs of the product
    always_comb
    begin
        nudged   = WIDE_W'(prod_reg) + NUDGE;
        srd_next = nudged[ACC_W+ACC_W-2:ACC_W-1];
    end

    // Stage 3: arithmetic shift, bump when the dropped bits pass half, or reach it for a non-negative value
    always_comb
    begin
        mask   = ACC_W'(((ACC_W+1)'(1) << shift) - (ACC_W+1)'(1));
        rem    = srd_reg & mask;
        thr    = (mask >> 1) + ACC_W'(srd_reg[ACC_W-1]);
        y_next = (srd_reg >>> shift) + $signed(ACC_W'(rem > thr));
    end

    always_ff @(posedge clk)
    begin
        if (load.mul)
        begin
            prod_reg <= prod_next;
        end
        if (load.srd)
        begin
            srd_reg <= srd_next;
        end
        if (load.rnd)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire
